@@ rtl/prq_pkg.sv @@
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants of the packet ring queue: command and result
// payloads, controller/datapath interface and the code points.
// ----------------------------------------------------------------------------
package prq_pkg;

    // defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_SLOT_BYTES  = 2048;

    // fixed field widths
    localparam int DATA_W     = 64;
    localparam int BC_W       = 4;
    localparam int LEN_OUT_W  = 12;
    localparam int CAP_W      = 5;
    localparam int OCC_W      = 5;
    localparam int WORD_BYTES = 8;
    localparam int LANE_W     = 3;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [0:0] {
        REG_QUEUE_CAPACITY = 1'b0
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_OVERSIZE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DROP_NONE     = 2'd0,
        DROP_FULL     = 2'd1,
        DROP_OVERSIZE = 2'd2
    } drop_t;

    typedef enum logic [0:0] {
        CTRL_IDLE = 1'b0,
        CTRL_POP  = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [DATA_W-1:0] data_word;
        logic [BC_W-1:0]   byte_count;
        logic              last;
    } cmd_t;

    typedef struct packed {
        status_t              status;
        logic [DATA_W-1:0]    out_word;
        logic [BC_W-1:0]      out_bytes;
        logic                 out_last;
        logic [LEN_OUT_W-1:0] packet_length;
        logic [OCC_W-1:0]     occupancy;
    } res_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic push;
        logic clear;
        logic pop_empty;
        logic pop_issue;
        logic pop_finish;
        logic load_result;
    } dp_ctrl_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic has_packets;
    } dp_stat_t;

endpackage

@@ rtl/prq_ctrl.sv @@
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer of the packet ring queue: decodes an accepted command and runs
// the two-step pop (storage read, then result).
// ----------------------------------------------------------------------------
module prq_ctrl
    import prq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] operation,
    input  dp_stat_t   stat,
    output logic       busy,
    output logic       done,
    output dp_ctrl_t   ctrl
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;
    logic        done_next;
    logic        accept;

    // state and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        accept     = 1'b0;
        busy       = 1'b0;
        case (state_reg)
            CTRL_IDLE:
            begin
                accept = start;
                if (accept)
                begin
                    case (operation)
                        OP_PUSH:  ctrl.push  = 1'b1;
                        OP_CLEAR: ctrl.clear = 1'b1;
                        OP_POP:
                        begin
                            if (stat.has_packets)
                            begin
                                ctrl.pop_issue = 1'b1;
                                state_next     = CTRL_POP;
                            end
                            else
                            begin
                                ctrl.pop_empty = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    ctrl.load_result = !ctrl.pop_issue;
                end
            end
            CTRL_POP:
            begin
                busy             = 1'b1;
                ctrl.pop_finish  = 1'b1;
                ctrl.load_result = 1'b1;
                state_next       = CTRL_IDLE;
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
        done_next = ctrl.load_result;
    end

    assign done = done_reg;

endmodule

@@ rtl/prq_datapath.sv @@
// ----------------------------------------------------------------------------
// prq_datapath
// Slot storage, length store, ring indices and result register of the
// packet ring queue. Storage is eight byte-lane banks so that any eight
// consecutive bytes of a slot are reached in one access.
// ----------------------------------------------------------------------------
module prq_datapath
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SLOT_BYTES  = DEF_SLOT_BYTES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic [CAP_W-1:0] capacity,
    input  dp_ctrl_t         ctrl,
    output dp_stat_t         stat,
    output res_t             result
);

    localparam int SLOT_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OFF_W      = $clog2(SLOT_BYTES + 1);
    localparam int SLOT_WORDS = (SLOT_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int WIDX_W     = $clog2(SLOT_WORDS);
    localparam int ROW_W      = OFF_W - LANE_W;
    localparam int ADDR_W     = SLOT_IDX_W + WIDX_W;
    localparam int BANK_DEPTH = 1 << ADDR_W;
    localparam int EXT_W      = (SLOT_IDX_W + 1 > CAP_W) ? SLOT_IDX_W + 1 : CAP_W;

    // state registers
    logic [SLOT_IDX_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_IDX_W-1:0] read_slot_reg, read_slot_next;
    logic [OCC_W-1:0]      count_reg, count_next;
    logic [OFF_W-1:0]      write_offset_reg, write_offset_next;
    logic [OFF_W-1:0]      read_offset_reg, read_offset_next;
    drop_t                 drop_mode_reg, drop_mode_next;
    res_t                  result_reg, result_next;

    // storage
    logic [7:0]            bank_mem [WORD_BYTES][BANK_DEPTH];
    logic [OFF_W-1:0]      len_mem [QUEUE_DEPTH];
    logic [7:0]            rd_data_reg [WORD_BYTES];
    logic [OFF_W-1:0]      len_rd_reg;

    logic [WORD_BYTES-1:0] bank_we;
    logic [ADDR_W-1:0]     bank_waddr [WORD_BYTES];
    logic [7:0]            bank_wdata [WORD_BYTES];
    logic [ADDR_W-1:0]     bank_raddr [WORD_BYTES];
    logic                  len_we;
    logic                  push_store;

    logic [EXT_W-1:0]      cap_eff;
    logic [BC_W-1:0]       bc_eff;
    drop_t                 dm_w;
    logic [OFF_W:0]        wo_end;
    logic [OFF_W-1:0]      wo_sum;
    logic [OFF_W-1:0]      pop_left;
    logic [BC_W-1:0]       pop_bytes;
    logic [OFF_W-1:0]      ro_sum;
    logic [DATA_W-1:0]     pop_word;

    // next ring index, wrapping at the effective capacity
    function automatic logic [SLOT_IDX_W-1:0] advance(
        input logic [SLOT_IDX_W-1:0] idx,
        input logic [EXT_W-1:0]      cap
    );
        logic [EXT_W-1:0] nxt;
        nxt = EXT_W'(idx) + EXT_W'(1);
        if (nxt >= cap || nxt >= EXT_W'(QUEUE_DEPTH))
        begin
            return '0;
        end
        return nxt[SLOT_IDX_W-1:0];
    endfunction

    // effective capacity and clamped byte count
    always_comb
    begin
        cap_eff = EXT_W'(capacity);
        if (capacity == '0)
        begin
            cap_eff = EXT_W'(1);
        end
        else if (EXT_W'(capacity) > EXT_W'(QUEUE_DEPTH))
        begin
            cap_eff = EXT_W'(QUEUE_DEPTH);
        end
        bc_eff = (cmd.byte_count > BC_W'(WORD_BYTES)) ? BC_W'(WORD_BYTES) : cmd.byte_count;
    end

    // push admission: full at first word, then slot overflow
    always_comb
    begin
        dm_w = drop_mode_reg;
        if (dm_w == DROP_NONE && write_offset_reg == '0
                && EXT_W'(count_reg) >= cap_eff)
        begin
            dm_w = DROP_FULL;
        end
        wo_end = {1'b0, write_offset_reg} + (OFF_W + 1)'(bc_eff);
        if (dm_w == DROP_NONE && wo_end > (OFF_W + 1)'(SLOT_BYTES))
        begin
            dm_w = DROP_OVERSIZE;
        end
        wo_sum     = wo_end[OFF_W-1:0];
        push_store = ctrl.push && (dm_w == DROP_NONE);
    end

    // lane addressing for push writes and pop reads
    always_comb
    begin
        logic [LANE_W-1:0] k;
        logic [ROW_W-1:0]  row;
        for (int b = 0; b < WORD_BYTES; b++)
        begin
            k   = LANE_W'(b) - write_offset_reg[LANE_W-1:0];
            row = write_offset_reg[OFF_W-1:LANE_W]
                + ROW_W'(LANE_W'(b) < write_offset_reg[LANE_W-1:0]);
            bank_waddr[b] = {write_slot_reg, row[WIDX_W-1:0]};
            bank_wdata[b] = cmd.data_word[8*k +: 8];
            bank_we[b]    = push_store && ({1'b0, k} < bc_eff);

            row = read_offset_reg[OFF_W-1:LANE_W]
                + ROW_W'(LANE_W'(b) < read_offset_reg[LANE_W-1:0]);
            bank_raddr[b] = {read_slot_reg, row[WIDX_W-1:0]};
        end
    end

    // byte-lane banks
    for (genvar g = 0; g < WORD_BYTES; g++)
    begin : g_bank
        always_ff @(posedge clk)
        begin
            if (bank_we[g])
            begin
                bank_mem[g][bank_waddr[g]] <= bank_wdata[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.pop_issue)
            begin
                rd_data_reg[g] <= bank_mem[g][bank_raddr[g]];
            end
        end
    end

    // packet length store
    assign len_we = push_store && cmd.last;

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[write_slot_reg] <= wo_sum;
        end
        if (ctrl.pop_issue)
        begin
            len_rd_reg <= len_mem[read_slot_reg];
        end
    end

    // pop word assembly from the registered lanes
    always_comb
    begin
        logic [LANE_W-1:0] lane;
        pop_left  = (len_rd_reg > read_offset_reg) ? len_rd_reg - read_offset_reg : '0;
        pop_bytes = (pop_left > OFF_W'(WORD_BYTES)) ? BC_W'(WORD_BYTES)
                                                    : BC_W'(pop_left);
        ro_sum    = read_offset_reg + OFF_W'(pop_bytes);
        for (int k = 0; k < WORD_BYTES; k++)
        begin
            lane = LANE_W'(k) + read_offset_reg[LANE_W-1:0];
            pop_word[8*k +: 8] = (BC_W'(k) < pop_bytes) ? rd_data_reg[lane] : 8'h00;
        end
    end

    // ring state update and result
    always_comb
    begin
        write_slot_next   = write_slot_reg;
        read_slot_next    = read_slot_reg;
        count_next        = count_reg;
        write_offset_next = write_offset_reg;
        read_offset_next  = read_offset_reg;
        drop_mode_next    = drop_mode_reg;
        result_next       = '0;
        result_next.status = STAT_OK;

        if (ctrl.push)
        begin
            if (dm_w == DROP_NONE)
            begin
                if (cmd.last)
                begin
                    write_slot_next   = advance(write_slot_reg, cap_eff);
                    count_next        = count_reg + OCC_W'(1);
                    write_offset_next = '0;
                end
                else
                begin
                    write_offset_next = wo_sum;
                end
            end
            else
            begin
                result_next.status = (dm_w == DROP_FULL) ? STAT_FULL : STAT_OVERSIZE;
                if (dm_w == DROP_OVERSIZE)
                begin
                    write_offset_next = '0;
                end
                drop_mode_next = cmd.last ? DROP_NONE : dm_w;
                if (cmd.last)
                begin
                    write_offset_next = '0;
                end
            end
        end
        else if (ctrl.clear)
        begin
            write_slot_next   = '0;
            read_slot_next    = '0;
            count_next        = '0;
            write_offset_next = '0;
            read_offset_next  = '0;
            drop_mode_next    = DROP_NONE;
        end
        else if (ctrl.pop_empty)
        begin
            result_next.status = STAT_EMPTY;
        end
        else if (ctrl.pop_finish)
        begin
            result_next.out_word      = pop_word;
            result_next.out_bytes     = pop_bytes;
            result_next.packet_length = LEN_OUT_W'(len_rd_reg);
            if (ro_sum >= len_rd_reg)
            begin
                result_next.out_last = 1'b1;
                read_offset_next     = '0;
                read_slot_next       = advance(read_slot_reg, cap_eff);
                count_next           = count_reg - OCC_W'(1);
            end
            else
            begin
                read_offset_next = ro_sum;
            end
        end
        result_next.occupancy = count_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg   <= '0;
            read_slot_reg    <= '0;
            count_reg        <= '0;
            write_offset_reg <= '0;
            read_offset_reg  <= '0;
            drop_mode_reg    <= DROP_NONE;
        end
        else
        begin
            write_slot_reg   <= write_slot_next;
            read_slot_reg    <= read_slot_next;
            count_reg        <= count_next;
            write_offset_reg <= write_offset_next;
            read_offset_reg  <= read_offset_next;
            drop_mode_reg    <= drop_mode_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.load_result)
        begin
            result_reg <= result_next;
        end
    end

    assign result           = result_reg;
    assign stat.has_packets = (count_reg != '0);

endmodule

@@ rtl/packet_ring_queue.sv @@
// ----------------------------------------------------------------------------
// packet_ring_queue
// Circular queue of whole packets held in fixed-size slots, with an APB
// register for the number of slots in use.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Push, clear, pop on
// an empty queue and the spare code never raise busy, so pushes stream at one
// word per clock; a pop that returns data runs in two steps, first reading the
// byte-lane storage banks and the length store, whose read data is registered,
// then forming the result with busy high. Every command gives one result,
// shown on result for exactly one cycle with done high; the receiver cannot
// stall it, so it must take the transfer in that cycle. The user must write the
// capacity register only while no command is in progress; the block does not enforce it.
module packet_ring_queue
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SLOT_BYTES  = DEF_SLOT_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cmd_t                  cmd,
    output logic                  done,
    output res_t                  result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    reg_index_t       reg_sel;
    logic             reg_hit;
    dp_ctrl_t         dp_ctrl;
    dp_stat_t         dp_stat;

    // register decode
    assign reg_sel = reg_index_t'(paddr[APB_ADDR_W-1]);
    assign reg_hit = (reg_sel == REG_QUEUE_CAPACITY);
    assign pready  = 1'b1;

    // capacity register write
    always_comb
    begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // register read
    assign prdata = reg_hit ? APB_DATA_W'(capacity_reg) : '0;

    // sequencer
    prq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (cmd.operation),
        .stat      (dp_stat),
        .busy      (busy),
        .done      (done),
        .ctrl      (dp_ctrl)
    );

    // storage and ring state
    prq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SLOT_BYTES  (SLOT_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .capacity (capacity_reg),
        .ctrl     (dp_ctrl),
        .stat     (dp_stat),
        .result   (result)
    );

endmodule

@@ sim/packet_ring_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_ring_queue_tb
// Self-checking bench for the packet ring queue. A directed table covers the
// corner cases: empty pop, the spare opcode, short words, over-long byte
// counts, zero-length packets, full rejection, clear, pop during an open
// push and index wrap. A long-packet pass fills a slot exactly and overruns
// another. Randomised packet traffic follows, over several capacity settings
// with random idle gaps. Each result is compared field by field with its
// prediction, from a local model of the queue or from a typed directed row.
// ----------------------------------------------------------------------------
module packet_ring_queue_tb;
    import prq_pkg::*;

    localparam int QD           = DEF_QUEUE_DEPTH;
    localparam int SB           = DEF_SLOT_BYTES;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 500;
    localparam int PHASES       = 7;

    // capacity for each random phase, extremes included
    localparam logic [CAP_W-1:0] PHASE_CAPS [PHASES] = '{
        5'd16, 5'd0, 5'd3, 5'd31, 5'd1, 5'd17, 5'd5
    };

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] data;
        logic [BC_W-1:0]   bc;
        logic              last;
        logic              typed;
        status_t           status;
        logic [OCC_W-1:0]  occ;
    } directed_row_t;

    // directed rows, run with a capacity of two; typed rows carry their answer
    localparam int DIRECTED_COUNT = 24;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // pop from an empty queue after reset
        '{OP_POP,   64'h0,                   4'd0,  1'b0, 1'b1, STAT_EMPTY, 5'd0},
        // spare opcode with every field bit set is ignored
        '{OP_NOP,   64'hffff_ffff_ffff_ffff, 4'd15, 1'b1, 1'b1, STAT_OK,    5'd0},
        '{OP_PUSH,  64'hffff_ffff_ffff_ffff, 4'd8,  1'b0, 1'b1, STAT_OK,    5'd0},
        // short word mid packet packs without a gap
        '{OP_PUSH,  64'h0123_4567_89ab_cdef, 4'd3,  1'b0, 1'b0, STAT_OK,    5'd0},
        // byte count above eight taken as eight
        '{OP_PUSH,  64'h8877_6655_4433_2211, 4'd15, 1'b1, 1'b0, STAT_OK,    5'd0},
        // zero-length packet
        '{OP_PUSH,  64'hdead_beef_dead_beef, 4'd0,  1'b1, 1'b0, STAT_OK,    5'd0},
        // queue full at the first word: whole packet rejected
        '{OP_PUSH,  64'h5555_5555_5555_5555, 4'd8,  1'b0, 1'b1, STAT_FULL,  5'd2},
        '{OP_PUSH,  64'haaaa_aaaa_aaaa_aaaa, 4'd8,  1'b1, 1'b1, STAT_FULL,  5'd2},
        '{OP_POP,   64'h0,                   4'd0,  1'b0, 1'b0, STAT_OK,    5'd0},
        '{OP_POP,   64'h0,                   4'd0,  1'b0, 1'b0, STAT_OK,    5'd0},
        '{OP_POP,   64'h0,                   4'd0,  1'b0, 1'b0, STAT_OK,    5'd0},
        // zero-length packet pops as one empty final word
        '{OP_POP,   64'h0,                   4'd0,  1'b0, 1'b0, STAT_OK,    5'd0},
        '{OP_POP,   64'h0,                   4'd0,  1'b0, 1'b1, STAT_EMPTY, 5'd0},
        '{OP_PUSH,  64'h1122_3344_5566_7788, 4'd8,  1'b0, 1'b1, STAT_OK,    5'd0},
        // clear abandons the open push
        '{OP_CLEAR, 64'h0,                   4'd0,  1'b0, 1'b1, STAT_OK,    5'd0},
        '{OP_PUSH,  64'h0000_0000_0000_00a5, 4'd1,  1'b1, 1'b0, STAT_OK,    5'd0},
        '{OP_PUSH,  64'hfedc_ba98_7654_3210, 4'd8,  1'b0, 1'b0, STAT_OK,    5'd0},
        // pop while a push is still open
        '{OP_POP,   64'h0,                   4'd0,  1'b0, 1'b0, STAT_OK,    5'd0},
        // commit into the last slot, write index wraps
        '{OP_PUSH,  64'h0f0e_0d0c_0b0a_0908, 4'd4,  1'b1, 1'b0, STAT_OK,    5'd0},
        '{OP_POP,   64'h0,                   4'd0,  1'b0, 1'b0, STAT_OK,    5'd0},
        '{OP_POP,   64'h0,                   4'd0,  1'b0, 1'b0, STAT_OK,    5'd0},
        '{OP_PUSH,  64'h8000_0000_0000_0001, 4'd8,  1'b0, 1'b0, STAT_OK,    5'd0},
        '{OP_NOP,   64'h0,                   4'd0,  1'b0, 1'b0, STAT_OK,    5'd0},
        '{OP_CLEAR, 64'h0,                   4'd0,  1'b0, 1'b1, STAT_OK,    5'd0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    cmd_t                  cmd;
    logic                  done;
    res_t                  result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // queue model state
    logic [CAP_W-1:0] cap_setting = CAP_RESET;
    int               tail_slot;
    int               head_slot;
    int               held_packets;
    int               fill_bytes;
    int               drain_bytes;
    drop_t            drop_state = DROP_NONE;
    logic [7:0]       slot_data [QD][SB];
    int               slot_len [QD];
    bit               slot_len_known [QD];

    res_t expected_results [$];
    res_t oldest_result;
    int   mismatches;
    int   cycle_count;
    int   items_sent;
    bit   idle_on;

    packet_ring_queue dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        mismatches++;
    endtask

    function automatic int effective_slots();
        if (cap_setting == 0)
            return 1;
        if (cap_setting > QD)
            return QD;
        return int'(cap_setting);
    endfunction

    function automatic int next_slot(input int s);
        int n;
        n = s + 1;
        if (n >= effective_slots() || n >= QD)
            n = 0;
        return n;
    endfunction

    // one command through the queue model, giving its result
    task automatic queue_step(input cmd_t c, output res_t r);
        int bc;
        int len;
        int left;
        int take;
        r  = '0;
        bc = (c.byte_count > WORD_BYTES) ? WORD_BYTES : int'(c.byte_count);
        case (c.operation)
            OP_PUSH:
            begin
                // full check only at the first word of a packet
                if (drop_state == DROP_NONE && fill_bytes == 0 &&
                    held_packets >= effective_slots())
                    drop_state = DROP_FULL;
                if (drop_state == DROP_NONE && fill_bytes + bc > SB)
                begin
                    drop_state = DROP_OVERSIZE;
                    fill_bytes = 0;
                end
                if (drop_state == DROP_NONE)
                begin
                    for (int i = 0; i < bc; i++)
                        slot_data[tail_slot][fill_bytes + i] = c.data_word[8*i +: 8];
                    fill_bytes += bc;
                    if (c.last)
                    begin
                        slot_len[tail_slot]       = fill_bytes;
                        slot_len_known[tail_slot] = 1'b1;
                        tail_slot                 = next_slot(tail_slot);
                        held_packets++;
                        fill_bytes = 0;
                    end
                end
                else
                begin
                    r.status = (drop_state == DROP_FULL) ? STAT_FULL : STAT_OVERSIZE;
                    if (c.last)
                    begin
                        drop_state = DROP_NONE;
                        fill_bytes = 0;
                    end
                end
            end
            OP_POP:
            begin
                if (held_packets == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    len  = slot_len[head_slot];
                    left = (len > drain_bytes) ? len - drain_bytes : 0;
                    take = (left > WORD_BYTES) ? WORD_BYTES : left;
                    for (int i = 0; i < take; i++)
                        r.out_word[8*i +: 8] = slot_data[head_slot][drain_bytes + i];
                    r.out_bytes     = BC_W'(take);
                    r.packet_length = LEN_OUT_W'(len);
                    drain_bytes += take;
                    if (drain_bytes >= len)
                    begin
                        r.out_last  = 1'b1;
                        drain_bytes = 0;
                        head_slot   = next_slot(head_slot);
                        held_packets--;
                    end
                end
            end
            OP_CLEAR:
            begin
                tail_slot    = 0;
                head_slot    = 0;
                held_packets = 0;
                fill_bytes   = 0;
                drain_bytes  = 0;
                drop_state   = DROP_NONE;
            end
            default:
            begin
            end
        endcase
        r.occupancy = OCC_W'(held_packets);
    endtask

    // random idle burst before a command, with junk on the command bus
    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            cmd   <= $bits(cmd_t)'({$urandom, $urandom, $urandom});
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // present one command and hold it until the block takes the transfer
    task automatic send_item(input cmd_t c, input bit typed, input res_t want,
                             output res_t got);
        maybe_idle();
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        queue_step(c, got);
        expected_results.push_back(typed ? want : got);
        items_sent++;
    endtask

    task automatic send_op(input op_t op, input logic [DATA_W-1:0] data,
                           input logic [BC_W-1:0] bc, input logic last, output res_t got);
        cmd_t c;
        c.operation  = op;
        c.data_word  = data;
        c.byte_count = bc;
        c.last       = last;
        send_item(c, 1'b0, '0, got);
    endtask

    function automatic logic [BC_W-1:0] random_byte_count();
        if ($urandom_range(0, 9) < 7)
            return BC_W'(WORD_BYTES);
        return BC_W'($urandom_range(0, 15));
    endfunction

    task automatic push_packet(input int words, input bit leave_open);
        res_t got;
        for (int w = 0; w < words; w++)
            send_op(OP_PUSH, {$urandom, $urandom}, random_byte_count(),
                    (w == words - 1) && !leave_open, got);
    endtask

    // pop the head packet word by word, or just its first words
    task automatic pop_packet(input bit stop_early);
        res_t got;
        int   remaining;
        remaining = stop_early ? $urandom_range(1, 2) : SB / WORD_BYTES + 1;
        do
        begin
            // head slot never committed since reset: empty the queue instead
            if (held_packets > 0 && !slot_len_known[head_slot])
            begin
                send_op(OP_CLEAR, {$urandom, $urandom}, random_byte_count(), 1'b0, got);
                return;
            end
            send_op(OP_POP, {$urandom, $urandom}, random_byte_count(),
                    1'($urandom_range(0, 1)), got);
            remaining--;
        end
        while (got.status == STAT_OK && !got.out_last && remaining > 0);
    endtask

    task automatic apb_read(output logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_QUEUE_CAPACITY, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // capacity write once every outstanding result is in, then read back
    task automatic set_capacity(input logic [CAP_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_QUEUE_CAPACITY, 2'b00};
        pwdata  <= {27'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        cap_setting = value;
        apb_read(readback);
        if (readback !== APB_DATA_W'(value))
            report_mismatch("capacity readback", readback, value);
    endtask

    // one slot filled exactly, then a packet that overruns its slot
    task automatic long_packets();
        res_t got;
        int   total;
        logic [BC_W-1:0] bc;
        for (int w = 0; w < SB / WORD_BYTES; w++)
            send_op(OP_PUSH, {$urandom, $urandom}, BC_W'(WORD_BYTES),
                    w == SB / WORD_BYTES - 1, got);
        total = 0;
        while (total <= SB)
        begin
            bc = BC_W'($urandom_range(5, 8));
            total += int'(bc);
            send_op(OP_PUSH, {$urandom, $urandom}, bc, 1'b0, got);
        end
        send_op(OP_PUSH, {$urandom, $urandom}, random_byte_count(), 1'b1, got);
        pop_packet(1'b0);
    endtask

    // result checking against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, occupancy", result.occupancy, 0);
            else
            begin
                oldest_result = expected_results.pop_front();
                if (result.status !== oldest_result.status)
                    report_mismatch("status", result.status, oldest_result.status);
                if (result.out_word !== oldest_result.out_word)
                    report_mismatch("out_word", result.out_word, oldest_result.out_word);
                if (result.out_bytes !== oldest_result.out_bytes)
                    report_mismatch("out_bytes", result.out_bytes, oldest_result.out_bytes);
                if (result.out_last !== oldest_result.out_last)
                    report_mismatch("out_last", result.out_last, oldest_result.out_last);
                if (result.packet_length !== oldest_result.packet_length)
                    report_mismatch("packet_length", result.packet_length,
                                    oldest_result.packet_length);
                if (result.occupancy !== oldest_result.occupancy)
                    report_mismatch("occupancy", result.occupancy, oldest_result.occupancy);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        res_t                  got;
        res_t                  want;
        cmd_t                  c;
        logic [APB_DATA_W-1:0] readback;
        int                    target;
        int                    pick;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        cmd     <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        idle_on = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register reset value
        apb_read(readback);
        if (readback !== APB_DATA_W'(CAP_RESET))
            report_mismatch("capacity after reset", readback, CAP_RESET);

        // directed table
        set_capacity(5'd2);
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            c.operation    = DIRECTED_ROWS[i].op;
            c.data_word    = DIRECTED_ROWS[i].data;
            c.byte_count   = DIRECTED_ROWS[i].bc;
            c.last         = DIRECTED_ROWS[i].last;
            want           = '0;
            want.status    = DIRECTED_ROWS[i].status;
            want.occupancy = DIRECTED_ROWS[i].occ;
            send_item(c, DIRECTED_ROWS[i].typed, want, got);
        end

        long_packets();

        // random packet traffic, one capacity per phase, no idling at the end
        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_capacity(PHASE_CAPS[phase]);
            idle_on = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
            target  = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    push_packet($urandom_range(1, 5), $urandom_range(0, 9) == 0);
                else if (pick < 85)
                    pop_packet(1'b0);
                else if (pick < 90)
                    pop_packet(1'b1);
                else if (pick < 94)
                    send_op(OP_CLEAR, {$urandom, $urandom}, random_byte_count(),
                            1'($urandom_range(0, 1)), got);
                else if (pick < 97)
                    send_op(OP_NOP, {$urandom, $urandom}, random_byte_count(),
                            1'($urandom_range(0, 1)), got);
                else
                    send_op(OP_PUSH, {$urandom, $urandom}, random_byte_count(),
                            1'($urandom_range(0, 1)), got);
            end
        end

        // drain
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
